/* sv/lrps_pkg.sv */
// shared types and constants for the lane region point steering unit
`timescale 1ns / 1ps

package lrps_pkg;

   // rectangle bounds are 16 bits so that any coordinate width up to 16 compares cleanly
   localparam int BOUND_WIDTH = 16;
   localparam int NUM_BOXES   = 5;

   localparam int BOX_LB = 0;
   localparam int BOX_LM = 1;
   localparam int BOX_LT = 2;
   localparam int BOX_RM = 3;
   localparam int BOX_RB = 4;

   typedef struct packed {
      logic [BOUND_WIDTH-1:0] x0;
      logic [BOUND_WIDTH-1:0] y0;
      logic [BOUND_WIDTH-1:0] x1;
      logic [BOUND_WIDTH-1:0] y1;
   } box_type;

   // inclusive bounds: left-bottom, left-middle, left-top, right-middle, right-bottom
   localparam box_type BOXES [NUM_BOXES] = '{
      '{x0: 16'd0,   y0: 16'd200, x1: 16'd160,  y1: 16'd400},
      '{x0: 16'd600, y0: 16'd100, x1: 16'd700,  y1: 16'd300},
      '{x0: 16'd250, y0: 16'd200, x1: 16'd300,  y1: 16'd300},
      '{x0: 16'd450, y0: 16'd70,  x1: 16'd550,  y1: 16'd240},
      '{x0: 16'd950, y0: 16'd130, x1: 16'd1300, y1: 16'd400}
   };

   typedef enum logic [1:0] {
      DIR_STRAIGHT = 2'd0,
      DIR_RIGHT    = 2'd1,
      DIR_LEFT     = 2'd2
   } dir_type;

   localparam logic [8:0] STEER_RIGHT    = 9'd265;
   localparam logic [8:0] STEER_STRAIGHT = 9'd320;
   localparam logic [8:0] STEER_LEFT     = 9'd376;

   localparam logic signed [9:0] SPEED_OFFSET = 10'sd300;
   localparam logic signed [9:0] SPEED_MAX    = 10'sd100;
   localparam logic signed [9:0] SPEED_MIN    = -10'sd100;

   // register indexes on the csr port
   localparam logic [1:0] CSR_HIT_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_STRAIGHT_SPEED = 2'd1;
   localparam logic [1:0] CSR_CORNER_SPEED   = 2'd2;

   typedef struct packed {
      logic [8:0] steering;
      logic [8:0] speed;
      dir_type    direction;
   } rsp_type;

endpackage

/* sv/lrps_box_hits.sv */
// point-in-rectangle tests for the five fixed regions
`timescale 1ns / 1ps

module lrps_box_hits #(
   parameter int COORD_WIDTH = 12
) (
   input  logic [COORD_WIDTH-1:0]        point_x,
   input  logic [COORD_WIDTH-1:0]        point_y,
   output logic [lrps_pkg::NUM_BOXES-1:0] hits
);

   logic [lrps_pkg::BOUND_WIDTH-1:0] x_ext;
   logic [lrps_pkg::BOUND_WIDTH-1:0] y_ext;

   assign x_ext = lrps_pkg::BOUND_WIDTH'(point_x);
   assign y_ext = lrps_pkg::BOUND_WIDTH'(point_y);

   for (genvar k = 0; k < lrps_pkg::NUM_BOXES; k++) begin : g_box
      assign hits[k] = (x_ext >= lrps_pkg::BOXES[k].x0) && (y_ext >= lrps_pkg::BOXES[k].y0) &&
                       (x_ext <= lrps_pkg::BOXES[k].x1) && (y_ext <= lrps_pkg::BOXES[k].y1);
   end

endmodule

/* sv/lrps_decide.sv */
// steering decision from the five region hit counts
`timescale 1ns / 1ps

module lrps_decide #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic [COUNT_WIDTH-1:0] counts [lrps_pkg::NUM_BOXES],
   input  logic [7:0]             hit_threshold,
   input  logic signed [7:0]      straight_speed,
   input  logic signed [7:0]      corner_speed,
   output lrps_pkg::rsp_type      result
);

   localparam int SUM_WIDTH = COUNT_WIDTH + 2;

   logic [COUNT_WIDTH-1:0] thr;
   logic [SUM_WIDTH-1:0]   left_sum;
   logic [SUM_WIDTH-1:0]   right_sum;
   logic [SUM_WIDTH-1:0]   right_plus_top;
   logic                   seen [lrps_pkg::NUM_BOXES];
   logic                   go_right;
   logic                   go_left;
   logic [8:0]             steer_sel;
   lrps_pkg::dir_type      dir_sel;
   logic signed [7:0]      sel_speed;
   logic signed [9:0]      speed_ext;
   logic signed [9:0]      speed_clamped;
   logic signed [9:0]      speed_cmd;

   assign thr = COUNT_WIDTH'(hit_threshold);

   for (genvar k = 0; k < lrps_pkg::NUM_BOXES; k++) begin : g_seen
      assign seen[k] = counts[k] >= thr;
   end

   assign left_sum = SUM_WIDTH'(counts[lrps_pkg::BOX_LB]) + SUM_WIDTH'(counts[lrps_pkg::BOX_LM])
                   + SUM_WIDTH'(counts[lrps_pkg::BOX_LT]);
   assign right_sum = SUM_WIDTH'(counts[lrps_pkg::BOX_RM]) + SUM_WIDTH'(counts[lrps_pkg::BOX_RB]);
   assign right_plus_top = right_sum + SUM_WIDTH'(counts[lrps_pkg::BOX_LT]);

   assign go_right = (seen[lrps_pkg::BOX_LB] && seen[lrps_pkg::BOX_LM]) ||
                     (seen[lrps_pkg::BOX_LT] && (left_sum > right_sum));
   assign go_left  = seen[lrps_pkg::BOX_RB] && seen[lrps_pkg::BOX_RM] &&
                     (right_plus_top > left_sum);

   always_comb begin
      if (go_right) begin
         steer_sel = lrps_pkg::STEER_RIGHT;
         dir_sel   = lrps_pkg::DIR_RIGHT;
         sel_speed = corner_speed;
      end else if (go_left) begin
         steer_sel = lrps_pkg::STEER_LEFT;
         dir_sel   = lrps_pkg::DIR_LEFT;
         sel_speed = corner_speed;
      end else begin
         steer_sel = lrps_pkg::STEER_STRAIGHT;
         dir_sel   = lrps_pkg::DIR_STRAIGHT;
         sel_speed = straight_speed;
      end
   end

   // clamp to +/-100 percent, then offset
   assign speed_ext = {{2{sel_speed[7]}}, sel_speed};

   always_comb begin
      if (speed_ext < lrps_pkg::SPEED_MIN) begin
         speed_clamped = lrps_pkg::SPEED_MIN;
      end else if (speed_ext > lrps_pkg::SPEED_MAX) begin
         speed_clamped = lrps_pkg::SPEED_MAX;
      end else begin
         speed_clamped = speed_ext;
      end
   end

   assign speed_cmd = speed_clamped + lrps_pkg::SPEED_OFFSET;
   assign result    = '{steering: steer_sel, speed: speed_cmd[8:0], direction: dir_sel};

endmodule

/* sv/lane_region_point_steering_unit.sv */
// top level of the lane region point steering unit
`timescale 1ns / 1ps
// a frame-end transaction is held in the input stage, then its result is loaded into the result register
// throughput: one transaction per cycle; a waiting result holds a frame-end transaction
// in the input stage and stalls every transaction behind it until the result is taken
// reset (synchronous, active high) clears the valid bits and the hit counters and
// loads threshold 15, straight speed 15, corner speed 14

module lane_region_point_steering_unit #(
   parameter int COUNT_WIDTH = 20,
   parameter int COORD_WIDTH = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // point stream
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_WIDTH-1:0] req_point_x,
   input  logic [COORD_WIDTH-1:0] req_point_y,
   input  logic                   req_point_valid,
   input  logic                   req_frame_end,
   // steering results
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [8:0]             rsp_steering,
   output logic [8:0]             rsp_speed,
   output logic [1:0]             rsp_direction,
   // configuration writes
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_data
);

   localparam logic [COUNT_WIDTH-1:0] CNT_FULL = '1;

   // configuration registers
   logic [7:0]        hit_threshold_ff;
   logic signed [7:0] straight_speed_ff;
   logic signed [7:0] corner_speed_ff;

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [COORD_WIDTH-1:0] s1_x_ff;
   logic [COORD_WIDTH-1:0] s1_y_ff;
   logic                   s1_point_ff;
   logic                   s1_frame_end_ff;

   // hit counters, one per region
   logic [COUNT_WIDTH-1:0] cnt_ff    [lrps_pkg::NUM_BOXES];
   logic [COUNT_WIDTH-1:0] cnt_in    [lrps_pkg::NUM_BOXES];
   logic [COUNT_WIDTH-1:0] cnt_bumped [lrps_pkg::NUM_BOXES];

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   lrps_pkg::rsp_type rsp_ff;
   lrps_pkg::rsp_type decision;

   logic                          req_fire;
   logic                          s1_fire;
   logic                          s1_decide;
   logic [lrps_pkg::NUM_BOXES-1:0] hits;

   // a frame-end item in the input stage may move only when the result register frees up
   assign s1_fire   = s1_valid_ff && (!s1_frame_end_ff || !rsp_valid_ff || rsp_ready);
   assign s1_decide = s1_fire && s1_frame_end_ff;
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // configuration writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_threshold_ff  <= 8'd15;
         straight_speed_ff <= 8'sd15;
         corner_speed_ff   <= 8'sd14;
      end else if (csr_write_en) begin
         case (csr_index)
            lrps_pkg::CSR_HIT_THRESHOLD:  hit_threshold_ff  <= csr_data;
            lrps_pkg::CSR_STRAIGHT_SPEED: straight_speed_ff <= csr_data;
            lrps_pkg::CSR_CORNER_SPEED:   corner_speed_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // input stage
   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff         <= req_point_x;
         s1_y_ff         <= req_point_y;
         s1_point_ff     <= req_point_valid;
         s1_frame_end_ff <= req_frame_end;
      end
   end

   lrps_box_hits #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_box_hits (
      .point_x(s1_x_ff),
      .point_y(s1_y_ff),
      .hits   (hits)
   );

   // saturating bump; the decision sees the counts with this point included,
   // then a frame end clears them
   for (genvar k = 0; k < lrps_pkg::NUM_BOXES; k++) begin : g_cnt
      assign cnt_bumped[k] = (s1_point_ff && hits[k] && (cnt_ff[k] != CNT_FULL))
                           ? cnt_ff[k] + COUNT_WIDTH'(1) : cnt_ff[k];

      always_comb begin
         if (s1_decide) begin
            cnt_in[k] = '0;
         end else if (s1_fire) begin
            cnt_in[k] = cnt_bumped[k];
         end else begin
            cnt_in[k] = cnt_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[k] <= '0;
         end else begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   lrps_decide #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_decide (
      .counts        (cnt_bumped),
      .hit_threshold (hit_threshold_ff),
      .straight_speed(straight_speed_ff),
      .corner_speed  (corner_speed_ff),
      .result        (decision)
   );

   // result register
   assign rsp_valid_in = s1_decide ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_decide) begin
         rsp_ff <= decision;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_steering  = rsp_ff.steering;
   assign rsp_speed     = rsp_ff.speed;
   assign rsp_direction = rsp_ff.direction;

   // checks

   logic cnt_all_zero;
   always_comb begin
      cnt_all_zero = 1'b1;
      for (int k = 0; k < lrps_pkg::NUM_BOXES; k++) begin
         if (cnt_ff[k] != '0) begin
            cnt_all_zero = 1'b0;
         end
      end
   end

   // a decision always leaves the counters cleared
   a_clear_after_decide: assert property (@(posedge clock) disable iff (reset)
      s1_decide |=> cnt_all_zero)
      else $error("hit counters not cleared after a frame-end transaction");

   // a new result only comes from a frame-end item leaving the input stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_frame_end_ff))
      else $error("result appeared without a frame-end transaction");

   // the input side stalls only behind a frame end blocked by a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_frame_end_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked frame-end transaction");

   // steering code and direction code agree
   a_code_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_ff.direction == lrps_pkg::DIR_RIGHT && rsp_ff.steering == lrps_pkg::STEER_RIGHT) ||
          (rsp_ff.direction == lrps_pkg::DIR_LEFT && rsp_ff.steering == lrps_pkg::STEER_LEFT) ||
          (rsp_ff.direction == lrps_pkg::DIR_STRAIGHT &&
           rsp_ff.steering == lrps_pkg::STEER_STRAIGHT)))
      else $error("steering and direction codes disagree");

endmodule
